// ===== design/prime_test_64_defines.svh =====
// ----------------------------------------------------------------------------
// prime_test_64 assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PRIME_TEST_64_DEFINES_SVH
`define PRIME_TEST_64_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define PT_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("prime_test_64 assertion failed");
// checked in every cycle, reset included
`define PT_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("prime_test_64 reset assertion failed");
`else
`define PT_ASSERT(label, prop)
`define PT_ASSERT_RST(label, prop)
`endif

`endif

// ===== design/pt64_pkg.sv =====
// ----------------------------------------------------------------------------
// pt64_pkg
// Shared types, operand selects and witness table for prime_test_64.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pt64_pkg;

    typedef logic [63:0] word_t;
    typedef logic [1:0]  sel_t;
    typedef logic [2:0]  widx_t;

    localparam int unsigned WIT_COUNT = 7;
    localparam widx_t WIT_LAST = widx_t'(WIT_COUNT - 1);

    // modular multiplier operand selects
    localparam sel_t SEL_RED  = 2'd0;  // witness mod n
    localparam sel_t SEL_SQ   = 2'd1;  // x * x mod n
    localparam sel_t SEL_MULB = 2'd2;  // x * b mod n

    typedef struct packed {
        logic  load;
        logic  res_step;
        logic  init_d;
        logic  strip;
        logic  mm_start;
        sel_t  mm_sel;
        logic  e_shift;
        widx_t wit_idx;
    } cmd_t;

    typedef struct packed {
        logic       n_lt2;
        logic       n_tiny;
        logic       n_small_fac;
        logic       d_odd;
        logic       e_msb;
        logic       b_zero;
        logic       x_one;
        logic       x_nm1;
        logic [5:0] s_cnt;
        logic       mm_done;
    } stat_t;

    function automatic word_t witness(input widx_t idx);
        word_t w;
        case (idx)
            3'd0:    w = 64'd2;
            3'd1:    w = 64'd325;
            3'd2:    w = 64'd9375;
            3'd3:    w = 64'd28178;
            3'd4:    w = 64'd450775;
            3'd5:    w = 64'd9780504;
            3'd6:    w = 64'd1795265022;
            default: w = 64'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/pt64_mulmod.sv =====
// ----------------------------------------------------------------------------
// pt64_mulmod
// Bit-serial (a * y) mod n, msb of y first, one double or add step per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pt64_mulmod (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                start,
    input  pt64_pkg::word_t    a_in,
    input  pt64_pkg::word_t    y_in,
    input  pt64_pkg::word_t    n_in,
    output logic               done,
    output pt64_pkg::word_t    result
);

    pt64_pkg::word_t acc_reg;
    pt64_pkg::word_t a_reg;
    pt64_pkg::word_t y_reg;
    logic [5:0]      cnt_reg;
    logic            phase_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [64:0] dbl;
    logic [64:0] sum;
    logic [64:0] src;
    logic [64:0] red;

    // acc stays below n; one conditional subtract brings it back
    always_comb begin
        dbl = {acc_reg, 1'b0};
        sum = {1'b0, acc_reg} + (y_reg[63] ? {1'b0, a_reg} : 65'd0);
        src = phase_reg ? sum : dbl;
        red = (src >= {1'b0, n_in}) ? (src - {1'b0, n_in}) : src;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                cnt_reg   <= 6'd0;
                acc_reg   <= 64'd0;
                a_reg     <= a_in;
                y_reg     <= y_in;
            end else if (busy_reg) begin
                acc_reg   <= red[63:0];
                phase_reg <= ~phase_reg;
                if (phase_reg) begin
                    y_reg   <= {y_reg[62:0], 1'b0};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

`default_nettype wire

// ===== design/pt64_dp.sv =====
// ----------------------------------------------------------------------------
// pt64_dp
// Datapath: candidate, residues mod 3 and 5, d and s, exponent, x and b.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pt64_dp (
    input  wire                aclk,
    input  wire                aresetn,
    input  pt64_pkg::cmd_t     cmd,
    input  pt64_pkg::word_t    candidate,
    output pt64_pkg::stat_t    stat
);

    pt64_pkg::word_t n_reg;
    pt64_pkg::word_t nm1_reg;
    pt64_pkg::word_t d_reg;
    pt64_pkg::word_t e_reg;
    pt64_pkg::word_t x_reg;
    pt64_pkg::word_t b_reg;
    logic [5:0]      s_reg;
    logic [1:0]      r3_reg;
    logic [2:0]      r5_reg;
    pt64_pkg::sel_t  dest_reg;

    pt64_pkg::word_t mm_a;
    pt64_pkg::word_t mm_y;
    pt64_pkg::word_t mm_res;
    logic            mm_done;

    logic [2:0] t3;
    logic [3:0] t5;
    logic [1:0] r3_next;
    logic [2:0] r5_next;

    always_comb begin
        mm_a = (cmd.mm_sel == pt64_pkg::SEL_RED) ? 64'd1 : x_reg;
        case (cmd.mm_sel)
            pt64_pkg::SEL_RED:  mm_y = pt64_pkg::witness(cmd.wit_idx);
            pt64_pkg::SEL_SQ:   mm_y = x_reg;
            pt64_pkg::SEL_MULB: mm_y = b_reg;
            default:            mm_y = x_reg;
        endcase
    end

    // running residues, candidate fed msb first
    always_comb begin
        t3 = {r3_reg, 1'b0} + {2'd0, e_reg[63]};
        t5 = {r5_reg, 1'b0} + {3'd0, e_reg[63]};
        r3_next = (t3 >= 3'd3) ? 2'(t3 - 3'd3) : t3[1:0];
        r5_next = (t5 >= 4'd5) ? 3'(t5 - 4'd5) : t5[2:0];
    end

    pt64_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mm_start),
        .a_in    (mm_a),
        .y_in    (mm_y),
        .n_in    (n_reg),
        .done    (mm_done),
        .result  (mm_res)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg  <= candidate;
            e_reg  <= candidate;
            r3_reg <= 2'd0;
            r5_reg <= 3'd0;
        end
        if (cmd.res_step) begin
            e_reg  <= {e_reg[62:0], 1'b0};
            r3_reg <= r3_next;
            r5_reg <= r5_next;
        end
        if (cmd.init_d) begin
            d_reg   <= n_reg - 64'd1;
            nm1_reg <= n_reg - 64'd1;
            s_reg   <= 6'd0;
        end
        if (cmd.strip) begin
            d_reg <= {1'b0, d_reg[63:1]};
            s_reg <= s_reg + 6'd1;
        end
        if (cmd.mm_start) begin
            dest_reg <= cmd.mm_sel;
        end
        if (cmd.e_shift) begin
            e_reg <= {e_reg[62:0], 1'b0};
        end
        if (mm_done) begin
            if (dest_reg == pt64_pkg::SEL_RED) begin
                b_reg <= mm_res;
                x_reg <= 64'd1;
                e_reg <= d_reg;
            end else begin
                x_reg <= mm_res;
            end
        end
    end

    always_comb begin
        stat.n_lt2       = (n_reg < 64'd2);
        stat.n_tiny      = (n_reg == 64'd2) || (n_reg == 64'd3) || (n_reg == 64'd5);
        stat.n_small_fac = !n_reg[0] || (r3_reg == 2'd0) || (r5_reg == 3'd0);
        stat.d_odd       = d_reg[0];
        stat.e_msb       = e_reg[63];
        stat.b_zero      = (b_reg == 64'd0);
        stat.x_one       = (x_reg == 64'd1);
        stat.x_nm1       = (x_reg == nm1_reg);
        stat.s_cnt       = s_reg;
        stat.mm_done     = mm_done;
    end

endmodule

`default_nettype wire

// ===== design/pt64_ctrl.sv =====
// ----------------------------------------------------------------------------
// pt64_ctrl
// Controller: screening, witness loop, square-and-multiply and final squarings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pt64_ctrl (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire                m_ready,
    output logic               m_is_prime,
    input  pt64_pkg::stat_t    stat,
    output pt64_pkg::cmd_t     cmd
);

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_RES     = 5'd1;
    localparam logic [4:0] ST_DECIDE  = 5'd2;
    localparam logic [4:0] ST_STRIP   = 5'd3;
    localparam logic [4:0] ST_WRED    = 5'd4;
    localparam logic [4:0] ST_WRED_W  = 5'd5;
    localparam logic [4:0] ST_WCHK    = 5'd6;
    localparam logic [4:0] ST_SQ      = 5'd7;
    localparam logic [4:0] ST_SQ_W    = 5'd8;
    localparam logic [4:0] ST_MULB    = 5'd9;
    localparam logic [4:0] ST_MULB_W  = 5'd10;
    localparam logic [4:0] ST_NEXTBIT = 5'd11;
    localparam logic [4:0] ST_TEST    = 5'd12;
    localparam logic [4:0] ST_SQ2     = 5'd13;
    localparam logic [4:0] ST_SQ2_W   = 5'd14;
    localparam logic [4:0] ST_CHK2    = 5'd15;
    localparam logic [4:0] ST_OUT     = 5'd16;

    logic [4:0]           state_reg, state_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic [5:0]           j_reg, j_next;
    pt64_pkg::widx_t      k_reg, k_next;
    logic                 prime_reg, prime_next;
    logic                 round_pass;
    logic                 round_fail;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        prime_next = prime_reg;
        round_pass = 1'b0;
        round_fail = 1'b0;
        cmd        = '0;
        cmd.mm_sel  = pt64_pkg::SEL_SQ;
        cmd.wit_idx = k_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = 6'd0;
                    state_next = ST_RES;
                end
            end
            ST_RES: begin
                cmd.res_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.n_lt2) begin
                    prime_next = 1'b0;
                    state_next = ST_OUT;
                end else if (stat.n_tiny) begin
                    prime_next = 1'b1;
                    state_next = ST_OUT;
                end else if (stat.n_small_fac) begin
                    prime_next = 1'b0;
                    state_next = ST_OUT;
                end else begin
                    cmd.init_d = 1'b1;
                    k_next     = '0;
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (stat.d_odd) begin
                    state_next = ST_WRED;
                end else begin
                    cmd.strip = 1'b1;
                end
            end
            ST_WRED: begin
                cmd.mm_start = 1'b1;
                cmd.mm_sel   = pt64_pkg::SEL_RED;
                state_next   = ST_WRED_W;
            end
            ST_WRED_W: begin
                if (stat.mm_done) begin
                    state_next = ST_WCHK;
                end
            end
            ST_WCHK: begin
                // witness that is a multiple of n counts as passed
                if (stat.b_zero) begin
                    round_pass = 1'b1;
                end else begin
                    cnt_next   = 6'd63;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.mm_start = 1'b1;
                cmd.mm_sel   = pt64_pkg::SEL_SQ;
                state_next   = ST_SQ_W;
            end
            ST_SQ_W: begin
                if (stat.mm_done) begin
                    state_next = stat.e_msb ? ST_MULB : ST_NEXTBIT;
                end
            end
            ST_MULB: begin
                cmd.mm_start = 1'b1;
                cmd.mm_sel   = pt64_pkg::SEL_MULB;
                state_next   = ST_MULB_W;
            end
            ST_MULB_W: begin
                if (stat.mm_done) begin
                    state_next = ST_NEXTBIT;
                end
            end
            ST_NEXTBIT: begin
                cmd.e_shift = 1'b1;
                if (cnt_reg == 6'd0) begin
                    state_next = ST_TEST;
                end else begin
                    cnt_next   = cnt_reg - 6'd1;
                    state_next = ST_SQ;
                end
            end
            ST_TEST: begin
                if (stat.x_one || stat.x_nm1) begin
                    round_pass = 1'b1;
                end else if (stat.s_cnt <= 6'd1) begin
                    round_fail = 1'b1;
                end else begin
                    j_next     = stat.s_cnt - 6'd1;
                    state_next = ST_SQ2;
                end
            end
            ST_SQ2: begin
                cmd.mm_start = 1'b1;
                cmd.mm_sel   = pt64_pkg::SEL_SQ;
                state_next   = ST_SQ2_W;
            end
            ST_SQ2_W: begin
                if (stat.mm_done) begin
                    state_next = ST_CHK2;
                end
            end
            ST_CHK2: begin
                if (stat.x_nm1) begin
                    round_pass = 1'b1;
                end else if (j_reg == 6'd1) begin
                    round_fail = 1'b1;
                end else begin
                    j_next     = j_reg - 6'd1;
                    state_next = ST_SQ2;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (round_pass) begin
            if (k_reg == pt64_pkg::WIT_LAST) begin
                prime_next = 1'b1;
                state_next = ST_OUT;
            end else begin
                k_next     = k_reg + 3'd1;
                state_next = ST_WRED;
            end
        end
        if (round_fail) begin
            prime_next = 1'b0;
            state_next = ST_OUT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg   <= cnt_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        prime_reg <= prime_next;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = (state_reg == ST_OUT);
    assign m_is_prime = prime_reg;

endmodule

`default_nettype wire

// ===== design/prime_test_64.sv =====
// ----------------------------------------------------------------------------
// prime_test_64
// Deterministic Miller-Rabin primality test of one unsigned 64-bit candidate.
// ----------------------------------------------------------------------------
// One candidate is in flight at a time: s_ready is high only while idle and
// the single result waits in m_valid/m_is_prime until taken. Every candidate
// is first loaded and screened (bit-serial residues mod 3 and 5), and those
// below 2, equal to 2, 3 or 5, or with a factor 2, 3 or 5 are answered
// then. The rest run up to seven witness rounds, all on one shared bit-serial
// modular multiplier that works out each (a*b) mod n. A round costs one
// witness reduction, 64 squarings, one multiply per set bit of d and up to
// s-1 final squarings; the set bits of d and the final squarings together
// stay under 64, so a round is at most 128 multiplies, and a prime runs all
// seven rounds while a composite stops at the first round that it fails.
`timescale 1ns / 1ps
`default_nettype none

`include "prime_test_64_defines.svh"

module prime_test_64 (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            s_valid,
    output logic           s_ready,
    input  wire  [63:0]    s_candidate,
    output logic           m_valid,
    input  wire            m_ready,
    output logic           m_is_prime
);

    pt64_pkg::cmd_t  cmd;
    pt64_pkg::stat_t stat;

    pt64_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_is_prime (m_is_prime),
        .stat       (stat),
        .cmd        (cmd)
    );

    pt64_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .candidate (s_candidate),
        .stat      (stat)
    );

    // one transaction at a time: never ready while a result is pending
    `PT_ASSERT(a_one_in_flight, m_valid |-> !s_ready)
    `PT_ASSERT(a_no_instant_result, (s_valid && s_ready) |=> !m_valid)
    // multiplier completion is a single-cycle pulse
    `PT_ASSERT(a_done_pulse, stat.mm_done |=> !stat.mm_done)
    `PT_ASSERT_RST(a_reset_quiet, !aresetn |=> !m_valid)

endmodule

`default_nettype wire

// ===== verif/prime_test_64_tb.sv =====
// ----------------------------------------------------------------------------
// prime_test_64_tb
// Drives candidates into prime_test_64 and checks each is_prime answer against
// an in-bench Miller-Rabin predictor, with random idles on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_test_64_tb;

    localparam longint unsigned CYCLE_LIMIT = 64'd120_000_000;
    localparam int unsigned     TAIL_CYCLES = 400;

    typedef struct {
        pt64_pkg::word_t value;
        bit              drain_first;
    } cand_item_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_candidate;
    logic        m_valid;
    logic        m_ready;
    logic        m_is_prime;

    cand_item_t   cand_q[$];
    bit           verdict_q[$];
    int unsigned  fail_cnt = 0;
    longint unsigned cycle_cnt = 0;
    int unsigned  send_gap = 0;
    int unsigned  recv_gap = 0;

    prime_test_64 dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_candidate (s_candidate),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_is_prime  (m_is_prime)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // (a * b) mod n with a full-width product
    function automatic pt64_pkg::word_t mulmod(input pt64_pkg::word_t a,
                                               input pt64_pkg::word_t b,
                                               input pt64_pkg::word_t n);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return pt64_pkg::word_t'(prod % {64'd0, n});
    endfunction

    // one strong-probable-prime round for odd n >= 7
    function automatic bit sprp_round(input pt64_pkg::word_t n, input pt64_pkg::word_t w);
        pt64_pkg::word_t d;
        pt64_pkg::word_t x;
        pt64_pkg::word_t b;
        int    s;
        d = n - 1;
        s = 0;
        while (d[0] == 1'b0) begin
            d = d >> 1;
            s++;
        end
        x = 1;
        b = w % n;
        while (d != 0) begin
            if (d[0]) x = mulmod(x, b, n);
            b = mulmod(b, b, n);
            d = d >> 1;
        end
        if (x == 1 || x == n - 1) return 1'b1;
        for (int i = 1; i < s; i++) begin
            x = mulmod(x, x, n);
            if (x == n - 1) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit primality(input pt64_pkg::word_t n);
        if (n < 2) return 1'b0;
        if (n == 2 || n == 3 || n == 5) return 1'b1;
        if (n % 2 == 0 || n % 3 == 0 || n % 5 == 0) return 1'b0;
        for (int k = 0; k < pt64_pkg::WIT_COUNT; k++) begin
            // witness that is a multiple of n counts as passed
            if (pt64_pkg::witness(pt64_pkg::widx_t'(k)) % n == 0) continue;
            if (!sprp_round(n, pt64_pkg::witness(pt64_pkg::widx_t'(k)))) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(300, 20);
    endfunction

    function automatic void add_cand(input pt64_pkg::word_t v, input bit drain);
        cand_item_t it;
        it.value = v;
        it.drain_first = drain;
        cand_q.push_back(it);
    endfunction

    // driver
    always @(posedge aclk) begin
        logic        nxt_valid;
        logic [63:0] nxt_cand;
        nxt_valid = s_valid;
        nxt_cand  = s_candidate;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                verdict_q.push_back(primality(s_candidate));
                void'(cand_q.pop_front());
                nxt_valid = 1'b0;
                send_gap = pick_gap();
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (cand_q.size() > 0) begin
                    if (!cand_q[0].drain_first || verdict_q.size() == 0) begin
                        nxt_valid = 1'b1;
                        nxt_cand  = cand_q[0].value;
                    end
                end
            end
        end
        s_valid     <= nxt_valid;
        s_candidate <= nxt_cand;
    end

    // monitor
    always @(posedge aclk) begin
        logic nxt_ready;
        bit   want;
        nxt_ready = m_ready;
        if (!aresetn) begin
            nxt_ready = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("is_prime transaction with nothing expected: actual %0d", m_is_prime);
                    fail_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_is_prime !== want) begin
                        $error("is_prime mismatch: expected %0d actual %0d", want, m_is_prime);
                        fail_cnt++;
                    end
                end
                recv_gap = pick_gap();
            end
            if (recv_gap > 0) begin
                nxt_ready = 1'b0;
                recv_gap--;
            end else begin
                nxt_ready = 1'b1;
            end
        end
        m_ready <= nxt_ready;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL prime_test_64");
            $finish;
        end
    end

    initial begin
        pt64_pkg::word_t v;
        int unsigned r;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_candidate = '0;
        m_ready     = 1'b0;

        // directed: edges, tiny primes, small factors, witness multiples, pseudoprimes
        add_cand(64'd0, 0);
        add_cand(64'd1, 0);
        add_cand(64'd2, 0);
        add_cand(64'd3, 0);
        add_cand(64'd4, 0);
        add_cand(64'd5, 0);
        add_cand(64'd6, 0);
        add_cand(64'd7, 0);
        add_cand(64'd9, 0);
        add_cand(64'd13, 0);                     // divides witness 325
        add_cand(64'd49, 0);
        add_cand(64'd41041, 0);                  // carmichael number
        add_cand(64'd3215031751, 0);             // strong pseudoprime to 2,3,5,7
        add_cand(64'hFFFF_FFFF_FFFF_FFFF, 0);
        add_cand(64'hFFFF_FFFF_FFFF_FFC5, 0);    // largest 64-bit prime
        add_cand(64'h1FFF_FFFF_FFFF_FFFF, 0);    // mersenne prime 2^61-1
        add_cand(64'h8000_0000_0000_0000, 0);
        add_cand(64'hAAAA_AAAA_AAAA_AAAB, 0);
        add_cand(64'd4294967291, 0);

        for (int i = 0; i < 131; i++) begin
            r = $urandom_range(99);
            if (r < 35) begin
                v = $urandom_range(65535);
            end else if (r < 65) begin
                v = {$urandom, $urandom};
            end else begin
                // screened-through candidates exercise the witness rounds
                do begin
                    if (r < 92) v = {32'd0, $urandom} | 64'd1;
                    else        v = {$urandom, $urandom} | 64'd1;
                end while (v % 3 == 0 || v % 5 == 0 || v < 7);
            end
            add_cand(v, i == 75);
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (cand_q.size() != 0 || verdict_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_cnt == 0 && verdict_q.size() == 0) begin
            $display("PASS prime_test_64");
        end else begin
            $display("FAIL prime_test_64");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/pt64_pkg.sv
design/pt64_mulmod.sv
design/pt64_dp.sv
design/pt64_ctrl.sv
design/prime_test_64.sv
verif/prime_test_64_tb.sv
